// ===== hdl/srwh_pkg.sv =====
// ----------------------------------------------------------------------------
// srwh_pkg: shared types, constants and round functions
// Lane bundle type, initial constants, operation codes, word normalisation
// and the sip round used by both the word mixer and the finaliser.
// ----------------------------------------------------------------------------
package srwh_pkg;

  // operation codes
  localparam logic [1:0] OP_RAW    = 2'd0;
  localparam logic [1:0] OP_DOUBLE = 2'd1;
  localparam logic [1:0] OP_FLOAT  = 2'd2;

  // initial lane constants
  localparam logic [63:0] LANE_INIT0 = 64'h736f6d6570736575;
  localparam logic [63:0] LANE_INIT1 = 64'h646f72616e646f6d;
  localparam logic [63:0] LANE_INIT2 = 64'h6c7967656e657261;
  localparam logic [63:0] LANE_INIT3 = 64'h7465646279746573;

  localparam logic [63:0] FINAL_XOR  = 64'h00000000000000ff;
  localparam int unsigned HashW      = 30;

  // canonical codes after normalisation
  localparam logic [63:0] DOUBLE_NAN     = 64'h7FF0000000000001;
  localparam logic [63:0] DOUBLE_NEGZERO = 64'h8000000000000000;
  localparam logic [10:0] DOUBLE_EXP_ALL = 11'h7ff;
  localparam logic [31:0] FLOAT_NAN      = 32'h7F800001;
  localparam logic [31:0] FLOAT_NEGZERO  = 32'h80000000;
  localparam logic [7:0]  FLOAT_EXP_ALL  = 8'hff;

  // hand-off queue between word mixer and finaliser
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } lanes_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             full;
    logic             empty;
  } q_status_t;

  // lanes at the start of a hash
  function automatic lanes_t lanes_init(input logic [31:0] seed);
    lanes_t r;
    r.v0 = {32'd0, seed} ^ LANE_INIT0;
    r.v1 = LANE_INIT1;
    r.v2 = {32'd0, seed} ^ LANE_INIT2;
    r.v3 = LANE_INIT3;
    return r;
  endfunction

  // one sip round
  function automatic lanes_t sip_round(input lanes_t s);
    lanes_t r;
    r    = s;
    r.v0 = r.v0 + r.v1;
    r.v2 = r.v2 + r.v3;
    r.v1 = {r.v1[50:0], r.v1[63:51]};
    r.v3 = {r.v3[50:0], r.v3[63:51]};
    r.v1 = r.v1 ^ r.v0;
    r.v3 = r.v3 ^ r.v2;
    r.v0 = {r.v0[31:0], r.v0[63:32]};
    r.v2 = r.v2 + r.v1;
    r.v0 = r.v0 + r.v3;
    r.v1 = {r.v1[46:0], r.v1[63:47]};
    r.v3 = {r.v3[42:0], r.v3[63:43]};
    r.v1 = r.v1 ^ r.v2;
    r.v3 = r.v3 ^ r.v0;
    r.v2 = {r.v2[31:0], r.v2[63:32]};
    return r;
  endfunction

  // canonical nan and zero for doubles
  function automatic logic [63:0] norm_double(input logic [63:0] w);
    logic nan;
    nan = (w[62:52] == DOUBLE_EXP_ALL) && (w[51:0] != 52'd0);
    if (nan) begin
      return DOUBLE_NAN;
    end else if (w == DOUBLE_NEGZERO) begin
      return 64'd0;
    end
    return w;
  endfunction

  // canonical nan and zero for singles, upper half dropped
  function automatic logic [63:0] norm_float(input logic [63:0] w);
    logic [31:0] n;
    n = w[31:0];
    if ((n[30:23] == FLOAT_EXP_ALL) && (n[22:0] != 23'd0)) begin
      n = FLOAT_NAN;
    end else if (n == FLOAT_NEGZERO) begin
      n = 32'd0;
    end
    return {32'd0, n};
  endfunction

endpackage

// ===== hdl/srwh_front.sv =====
// ----------------------------------------------------------------------------
// srwh_front: word mixer
// Normalises each word, mixes it into the lanes with two sip rounds per
// cycle and hands the lanes of a finished message to the queue.
// ----------------------------------------------------------------------------
module srwh_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             operation_i,
  input  logic [63:0]            data_word_i,
  input  logic                   last_word_i,
  output logic                   push_valid_o,
  output srwh_pkg::lanes_t       push_lanes_o,
  input  srwh_pkg::q_status_t    q_status_i
);
  import srwh_pkg::*;

  logic [31:0] seed_q, seed_d;
  lanes_t      lanes_q, lanes_d;
  logic        idle_q, idle_d;
  logic        accept;
  logic [63:0] word;
  lanes_t      mixed;
  lanes_t      round_one;

  // words are taken whenever the queue can hold a finished message
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // normalisation
  always_comb begin
    unique case (operation_i)
      OP_DOUBLE: word = norm_double(data_word_i);
      OP_FLOAT:  word = norm_float(data_word_i);
      default:   word = data_word_i;
    endcase
  end

  // word into lane three, two rounds, word into lane zero
  always_comb begin
    round_one    = lanes_q;
    round_one.v3 = lanes_q.v3 ^ word;
    round_one    = sip_round(round_one);
    mixed        = sip_round(round_one);
    mixed.v0     = mixed.v0 ^ word;
  end

  // lanes of a finished message with the finalisation constant applied
  always_comb begin
    push_lanes_o    = mixed;
    push_lanes_o.v2 = mixed.v2 ^ FINAL_XOR;
  end
  assign push_valid_o = accept && last_word_i;

  // lane and seed update
  always_comb begin
    seed_d  = seed_q;
    lanes_d = lanes_q;
    idle_d  = idle_q;
    if (cfg_we_i) begin
      seed_d = cfg_wdata_i;
    end
    priority if (accept && last_word_i) begin
      lanes_d = lanes_init(seed_q);
      idle_d  = 1'b1;
    end else if (accept) begin
      lanes_d = mixed;
      idle_d  = 1'b0;
    end else if (cfg_we_i && idle_q) begin
      lanes_d = lanes_init(cfg_wdata_i);
    end else begin
      lanes_d = lanes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      lanes_q <= lanes_init(32'd0);
      idle_q  <= 1'b1;
    end else begin
      seed_q  <= seed_d;
      lanes_q <= lanes_d;
      idle_q  <= idle_d;
    end
  end

endmodule

// ===== hdl/srwh_queue.sv =====
// ----------------------------------------------------------------------------
// srwh_queue: hand-off queue
// Short first-in first-out store of lane sets between the word mixer and
// the finaliser, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module srwh_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  input  srwh_pkg::lanes_t       push_lanes_i,
  input  logic                   pop_i,
  output srwh_pkg::lanes_t       head_lanes_o,
  output srwh_pkg::q_status_t    status_o
);
  import srwh_pkg::*;

  lanes_t           entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign status_o.count = count_q;
  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.empty = (count_q == '0);

  assign push = push_valid_i && !status_o.full;
  assign pop  = pop_i && !status_o.empty;

  assign head_lanes_o = entry_q[rd_ptr_q];

  // pointer wrap
  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    if (p == QPtrW'(QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_lanes_i;
    end
  end

endmodule

// ===== hdl/srwh_final.sv =====
// ----------------------------------------------------------------------------
// srwh_final: finaliser
// Runs the four closing rounds as two pipelined stages of two rounds each
// and holds the masked lane XOR in the output register.
// ----------------------------------------------------------------------------
module srwh_final (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srwh_pkg::lanes_t                  head_lanes_i,
  input  srwh_pkg::q_status_t               q_status_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [srwh_pkg::HashW-1:0]        hash_value_o
);
  import srwh_pkg::*;

  lanes_t            mid_q, mid_d;
  logic              mid_valid_q;
  logic              mid_load;
  logic              out_load;
  logic              out_valid_q;
  logic [HashW-1:0]  hash_q, hash_d;
  lanes_t            tail;
  logic [63:0]       folded;

  // stage enables
  assign out_load = !out_valid_q || out_ready_i;
  assign mid_load = !mid_valid_q || out_load;
  assign pop_o    = mid_load && !q_status_i.empty;

  // first two closing rounds
  assign mid_d = sip_round(sip_round(head_lanes_i));

  // last two closing rounds and lane fold
  always_comb begin
    tail   = sip_round(sip_round(mid_q));
    folded = tail.v0 ^ tail.v1 ^ tail.v2 ^ tail.v3;
    hash_d = folded[HashW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mid_load) begin
        mid_valid_q <= !q_status_i.empty;
      end
      if (out_load) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mid_q <= mid_d;
    end
    if (out_load && mid_valid_q) begin
      hash_q <= hash_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

// ===== hdl/sip_round_word_hash.sv =====
// ----------------------------------------------------------------------------
// sip_round_word_hash: keyed word-stream hash from sip rounds
// Word mixer, hand-off queue and pipelined finaliser.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle while the queue is not full: the word
// mixer normalises it and runs both of its sip rounds in the cycle of the
// transfer, so back-to-back words never stall on the lanes. A last word hands
// its lanes to a two-entry queue and the lanes restart from the seed at once,
// so the next message may follow in the very next cycle. The finaliser takes
// one queued message per cycle while its output is not held off and runs the
// four closing rounds over two pipelined stages, from the queue entry via the
// middle register to the output register. The input stalls only while both
// queue entries are full, that is while the output side has been held off. A
// seed written while no word of the current message has been mixed reloads
// the lanes at once; otherwise it applies from the next message.
// ----------------------------------------------------------------------------
module sip_round_word_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] data_word_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [29:0] hash_value_o
);
  import srwh_pkg::*;

  logic      push_valid;
  lanes_t    push_lanes;
  lanes_t    head_lanes;
  logic      pop;
  q_status_t q_status;

  srwh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .data_word_i  (data_word_i),
    .last_word_i  (last_word_i),
    .push_valid_o (push_valid),
    .push_lanes_o (push_lanes),
    .q_status_i   (q_status)
  );

  srwh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_lanes_i (push_lanes),
    .pop_i        (pop),
    .head_lanes_o (head_lanes),
    .status_o     (q_status)
  );

  srwh_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_lanes_i (head_lanes),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  // a finished message is never dropped on its way to the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_word_i) |=> !q_status.empty)
    else $error("last word transfer left the queue empty");

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= QCntW'(QDepth))
    else $error("hand-off queue count out of range");

  // push without pop grows the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && !pop) |=> (q_status.count == $past(q_status.count) + 1'b1))
    else $error("queue count did not follow a push");

  // the finaliser pops only a filled queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from an empty hand-off queue");

endmodule

// ===== dv/sip_round_word_hash_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sip_round_word_hash_test: self-checking bench for the keyed word hash
// Streams directed and random words through the valid/ready input, tracks
// the four hash lanes in a behavioural tracker and checks every emitted hash
// in order. Seed writes happen between phases, both at a message boundary
// and part way through a message. Both sides idle at random, the output
// side holds off long enough to stall the input, and the bench times out on
// a cycle limit.
// ----------------------------------------------------------------------------
module sip_round_word_hash_test;
  import srwh_pkg::*;

  // code outside the defined operations, mixed as a raw word
  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles = 400;

  // ---------------------------------------------------------------------------
  // lane tracker and expected hash store
  // ---------------------------------------------------------------------------
  class hash_tracker;
    logic [31:0] seed;
    lanes_t      lanes;
    bit          fresh;
    logic [29:0] pending_hashes[$];
    int unsigned errors;

    function new();
      seed   = '0;
      errors = 0;
      restart();
    endfunction

    // lanes back to the seeded start values
    function void restart();
      lanes.v0 = {32'd0, seed} ^ LANE_INIT0;
      lanes.v1 = LANE_INIT1;
      lanes.v2 = {32'd0, seed} ^ LANE_INIT2;
      lanes.v3 = LANE_INIT3;
      fresh    = 1'b1;
    endfunction

    // a new seed reloads the lanes only before the first word of a message
    function void load_seed(logic [31:0] value);
      seed = value;
      if (fresh) begin
        restart();
      end
    endfunction

    function logic [63:0] rotl(logic [63:0] x, int unsigned n);
      return (x << n) | (x >> (64 - n));
    endfunction

    function void mix_round();
      lanes.v0 = lanes.v0 + lanes.v1;
      lanes.v2 = lanes.v2 + lanes.v3;
      lanes.v1 = rotl(lanes.v1, 13) ^ lanes.v0;
      lanes.v3 = rotl(lanes.v3, 13) ^ lanes.v2;
      lanes.v0 = rotl(lanes.v0, 32);
      lanes.v2 = lanes.v2 + lanes.v1;
      lanes.v0 = lanes.v0 + lanes.v3;
      lanes.v1 = rotl(lanes.v1, 17) ^ lanes.v2;
      lanes.v3 = rotl(lanes.v3, 21) ^ lanes.v0;
      lanes.v2 = rotl(lanes.v2, 32);
    endfunction

    // nan and minus zero folded to one code each
    function logic [63:0] canon(logic [1:0] op, logic [63:0] w);
      logic [31:0] n;
      n = w[31:0];
      case (op)
        OP_DOUBLE: begin
          if (w[62:52] == DOUBLE_EXP_ALL && w[51:0] != 52'd0) return DOUBLE_NAN;
          if (w == DOUBLE_NEGZERO) return 64'd0;
          return w;
        end
        OP_FLOAT: begin
          if (n[30:23] == FLOAT_EXP_ALL && n[22:0] != 23'd0) n = FLOAT_NAN;
          else if (n == FLOAT_NEGZERO) n = 32'd0;
          return {32'd0, n};
        end
        default: return w;
      endcase
    endfunction

    // one accepted word: mix it, and on the last word queue the hash
    function void absorb_word(logic [1:0] op, logic [63:0] data, logic last);
      logic [63:0] w;
      logic [63:0] folded;
      w = canon(op, data);
      lanes.v3 = lanes.v3 ^ w;
      mix_round();
      mix_round();
      lanes.v0 = lanes.v0 ^ w;
      fresh = 1'b0;
      if (last) begin
        lanes.v2 = lanes.v2 ^ FINAL_XOR;
        repeat (4) mix_round();
        folded = lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3;
        pending_hashes.push_back(folded[29:0]);
        restart();
      end
    endfunction

    // one accepted hash against the oldest expectation
    function void check_hash(logic [29:0] got);
      logic [29:0] want;
      if (pending_hashes.size() == 0) begin
        $display("%0t: hash_value expected none, actual 0x%08h", $time, got);
        errors++;
        return;
      end
      want = pending_hashes.pop_front();
      if (got !== want) begin
        $display("%0t: hash_value expected 0x%08h, actual 0x%08h", $time, want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_hashes.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset and block
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OP_RAW;
  logic [63:0] data_word_i = '0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [29:0] hash_value_o;

  hash_tracker tracker;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sip_round_word_hash u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .data_word_i  (data_word_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sip_round_word_hash regression: fail");
      $finish;
    end
  end

  // transfer monitor: words first, then hashes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.absorb_word(operation_i, data_word_i, last_word_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_hash(hash_value_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // idle gaps: random per transfer, with stretches of none
  // ---------------------------------------------------------------------------
  function automatic int unsigned tx_gap();
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    return tx_burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic int unsigned rx_gap();
    if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
    return rx_burst ? 0 : $urandom_range(0, 19);
  endfunction

  // hash receiver, with a long hold-off on request
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = rx_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HoldCycles;
      end
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // word driver
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [1:0] op, logic [63:0] data, logic last);
    int unsigned gap;
    gap = tx_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    data_word_i <= data;
    last_word_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // sender pauses until every hash is back and the block has settled
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.load_seed(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random word, often steered onto nan, infinity and zero patterns
  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 11))
      0: w[62:52] = DOUBLE_EXP_ALL;
      1: begin
        w[62:52] = DOUBLE_EXP_ALL;
        w[51:0]  = '0;
      end
      2: w[62:0] = '0;
      3: w[30:23] = FLOAT_EXP_ALL;
      4: begin
        w[30:23] = FLOAT_EXP_ALL;
        w[22:0]  = '0;
      end
      5: w[30:0] = '0;
      default: ;
    endcase
    return w;
  endfunction

  // messages of random length, mostly short; may end part way
  task automatic run_phase(int unsigned target, bit squeeze);
    int unsigned sent;
    int unsigned len;
    logic [1:0]  op;
    sent = 0;
    if (squeeze) begin
      tx_burst = 1'b1;
      hold_req = 1'b1;
    end
    while (sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        op = ($urandom_range(0, 15) == 0) ? OP_UNDEF : 2'($urandom_range(0, 2));
        send_word(op, pick_word(), i == len - 1);
      end
      sent += len;
    end
    if ($urandom_range(0, 1) == 1) begin
      send_word(2'($urandom_range(0, 2)), pick_word(), 1'b0);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // raw extremes, reset seed
    send_word(OP_RAW, 64'h0, 1'b1);
    send_word(OP_RAW, '1, 1'b1);
    // double nan, nan with low fraction only, minus zero, infinity kept
    send_word(OP_DOUBLE, 64'h7FF8000000000000, 1'b0);
    send_word(OP_DOUBLE, 64'hFFF0000000000005, 1'b0);
    send_word(OP_DOUBLE, 64'h8000000000000000, 1'b0);
    send_word(OP_DOUBLE, 64'h7FF0000000000000, 1'b1);
    // float with junk in the upper half: nan, minus zero, negative nan, infinity
    send_word(OP_FLOAT, 64'hDEADBEEF7FC00000, 1'b0);
    send_word(OP_FLOAT, 64'hFFFFFFFF80000000, 1'b0);
    send_word(OP_FLOAT, 64'h00000000FF800001, 1'b0);
    send_word(OP_FLOAT, 64'h123456787F800000, 1'b1);
    // undefined operation mixes raw
    send_word(OP_UNDEF, 64'hA5A5A5A55A5A5A5A, 1'b1);
    // seed change part way through a message waits for the next one
    send_word(OP_DOUBLE, 64'h3FF0000000000000, 1'b0);
    send_word(OP_RAW, 64'h0123456789ABCDEF, 1'b0);
    drain();
    write_seed(32'hFFFFFFFF);
    send_word(OP_FLOAT, 64'h0, 1'b1);
    send_word(OP_RAW, 64'h0, 1'b1);
    drain();
    // seed change between messages reloads at once
    write_seed(32'h0);
    send_word(OP_DOUBLE, 64'h0, 1'b1);
    send_word(OP_FLOAT, '1, 1'b1);
    drain();

    // random phases over several seeds
    write_seed($urandom());
    run_phase(140, 1'b1);
    write_seed(32'hFFFFFFFF);
    run_phase(140, 1'b0);
    write_seed(32'h00000001);
    run_phase(140, 1'b1);
    write_seed(32'h80000000);
    run_phase(140, 1'b0);
    write_seed($urandom());
    run_phase(140, 1'b0);

    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("sip_round_word_hash regression: pass");
    end else begin
      $display("sip_round_word_hash regression: fail");
    end
    $finish;
  end

endmodule
